[sv/dds_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_pkg: shared types and constants for the decimal digit sum block
// Field widths, conversion stage split and the double-dabble step function.
// ---------------------------------------------------------------------------
package dds_pkg;

  localparam int VALUE_W    = 64;                 // binary input width
  localparam int DIGITS     = 20;                 // decimal digits of 2^64-1
  localparam int BCD_W      = DIGITS * 4;
  localparam int SUM_W      = 8;                  // digit sum, at most 171
  localparam int STEP_BITS  = 8;                  // input bits consumed per stage
  localparam int CONV_STAGES = VALUE_W / STEP_BITS;
  localparam int GROUP      = 5;                  // digits per first-level adder
  localparam int GROUPS     = DIGITS / GROUP;
  localparam int PART_W     = $clog2(GROUP * 9 + 1);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [PART_W-1:0]  part_t;

  // Conversion word: decimal digits on top, unconsumed binary bits below
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } conv_t;

  // STEP_BITS rounds of add-3 correction and one-bit shift
  function automatic conv_t dabble_bits(input conv_t x);
    conv_t    w;
    logic [3:0] d;
    w = x;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int k = 0; k < DIGITS; k++) begin
        d = w.bcd[k*4 +: 4];
        if (d >= 4'd5) begin
          w.bcd[k*4 +: 4] = d + 4'd3;
        end
      end
      {w.bcd, w.bin} = {w.bcd[BCD_W-2:0], w.bin, 1'b0};
    end
    return w;
  endfunction

endpackage

[sv/dds_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_in_if: input channel of the decimal digit sum block
// Valid/ready handshake carrying one unsigned 64-bit value per word.
// ---------------------------------------------------------------------------
interface dds_in_if;
  import dds_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[sv/dds_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_out_if: result channel of the decimal digit sum block
// Valid/ready handshake carrying one 8-bit digit sum per word.
// ---------------------------------------------------------------------------
interface dds_out_if;
  import dds_pkg::*;

  logic valid;
  logic ready;
  sum_t digit_sum;

  modport source (output valid, output digit_sum, input ready);
  modport sink   (input valid, input digit_sum, output ready);
endinterface

[sv/dds_bcd_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_bcd_stage: one registered binary-to-BCD conversion stage
// Consumes STEP_BITS binary bits by double dabble and holds the word.
// ---------------------------------------------------------------------------
module dds_bcd_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  dds_pkg::conv_t up_data,
  output logic          down_valid,
  input  logic          down_ready,
  output dds_pkg::conv_t down_data
);
  import dds_pkg::*;

  logic  valid;
  conv_t data;
  conv_t data_next;

  always_comb data_next = dabble_bits(up_data);

  // slot frees when empty or when the next stage takes it
  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;
endmodule

[sv/dds_sum.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_sum: two-stage registered adder tree over the decimal digits
// Groups of digits are summed first, then the group sums; drives the result.
// ---------------------------------------------------------------------------
module dds_sum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [dds_pkg::BCD_W-1:0] up_bcd,
  dds_out_if.source               sum_ch
);
  import dds_pkg::*;

  logic  part_valid;
  part_t part [GROUPS];
  part_t part_next [GROUPS];
  logic  part_ready;
  logic  total_valid;
  sum_t  total;
  sum_t  total_next;
  logic  total_ready;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        part_next[g] = part_next[g]
                     + part_t'(up_bcd[(g*GROUP + j)*4 +: 4]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total_next = total_next + sum_t'(part[g]);
    end
  end

  assign total_ready = !total_valid || sum_ch.ready;
  assign part_ready  = !part_valid || total_ready;
  assign up_ready    = part_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid  <= 1'b0;
      total_valid <= 1'b0;
    end else begin
      if (part_ready) begin
        part_valid <= up_valid;
      end
      if (total_ready) begin
        total_valid <= part_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_ready && up_valid) begin
      part <= part_next;
    end
    if (total_ready && part_valid) begin
      total <= total_next;
    end
  end

  assign sum_ch.valid     = total_valid;
  assign sum_ch.digit_sum = total;
endmodule

[sv/decimal_digit_sum_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_digit_sum_top: sum of the decimal digits of a 64-bit value
// Pipelined double-dabble conversion followed by a registered adder tree.
// ---------------------------------------------------------------------------
// Usage
//   value_ch : input words, one unsigned 64-bit value each (valid/ready).
//   sum_ch   : result words, one 8-bit digit sum (0..171) per input word.
//   A word is taken on a rising edge with valid and ready both high.
// Stages
//   Ten register stages: eight conversion stages of 8 binary bits each,
//   then two adder stages (five-digit group sums, then the final total,
//   which is the output register). The acceptance edge loads the first
//   stage; each word then moves on through the stages in order.
// Throughput
//   One word per cycle while sum_ch.ready is high. Every stage holds its
//   own valid bit and moves when empty or when the stage after it moves.
// Reset
//   Synchronous rst clears all valid bits; the block is ready at once.
// Back-pressure
//   While sum_ch.ready is low the result holds. Empty stages upstream still
//   fill, so value_ch.ready drops only once all ten stages are occupied;
//   nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module decimal_digit_sum_top (
  input  logic      clk,
  input  logic      rst,
  dds_in_if.sink    value_ch,
  dds_out_if.source sum_ch
);
  import dds_pkg::*;

  // stage chain; index 0 is the input side
  logic  stage_valid [CONV_STAGES+1];
  logic  stage_ready [CONV_STAGES+1];
  conv_t stage_data  [CONV_STAGES+1];

  assign stage_valid[0]     = value_ch.valid;
  assign stage_data[0].bin  = value_ch.value;
  assign stage_data[0].bcd  = '0;
  assign value_ch.ready     = stage_ready[0];

  for (genvar i = 0; i < CONV_STAGES; i++) begin : g_conv
    dds_bcd_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stage_valid[i]),
      .up_ready   (stage_ready[i]),
      .up_data    (stage_data[i]),
      .down_valid (stage_valid[i+1]),
      .down_ready (stage_ready[i+1]),
      .down_data  (stage_data[i+1])
    );
  end

  // all binary bits consumed: the digits are complete
  dds_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stage_valid[CONV_STAGES]),
    .up_ready (stage_ready[CONV_STAGES]),
    .up_bcd   (stage_data[CONV_STAGES].bcd),
    .sum_ch   (sum_ch)
  );
endmodule

[sv/dds_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_checker: port-level checks for the decimal digit sum block
// Watches both channels and is bound to the top level.
// ---------------------------------------------------------------------------
module dds_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dds_pkg::sum_t     digit_sum
);
  import dds_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digit_sum))
    else $error("result changed under stall");

  // a free output slot frees the whole chain
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_sum <= sum_t'(171))
    else $error("digit sum out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind decimal_digit_sum_top dds_checker u_dds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (value_ch.ready),
  .out_valid (sum_ch.valid),
  .out_ready (sum_ch.ready),
  .digit_sum (sum_ch.digit_sum)
);

[test/decimal_digit_sum_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_digit_sum_top_test: self-checking bench for the digit sum block
// Streams unsigned 64-bit values into decimal_digit_sum_top. A scoreboard
// works out each expected digit sum by repeated division by ten and checks
// the result words in order. Both channels idle at random, with one quiet
// stretch and one long result hold-off that fills the pipeline.
// ---------------------------------------------------------------------------
module decimal_digit_sum_top_test;
  import dds_pkg::*;

  localparam int     HALF_PERIOD   = 4;    // 8 ns clock
  localparam int     RESET_CYCLES  = 5;
  localparam int     RANDOM_VALUES = 750;
  localparam int     CALM_FIRST    = 300;  // random words sent with no idling
  localparam int     CALM_LAST     = 449;
  localparam int     IDLE_PERCENT  = 9;
  localparam int     HOLD_AT       = 120;  // sums checked before the hold-off
  localparam int     HOLD_CYCLES   = 80;   // well past the ten pipeline stages
  localparam int     DRAIN_CYCLES  = 12;   // room for any stray word after the last sum
  localparam int     REPORT_LIMIT  = 10;
  localparam value_t DECIMAL_BASE  = 64'd10;

  // Shapes of random value
  typedef enum int {
    KIND_FULL,        // every bit random
    KIND_SMALL,       // 0..999
    KIND_SHIFTED,     // random value of random bit length
    KIND_NINES,       // decimal digits weighted towards nine
    KIND_NEAR_POWER,  // a power of ten, a step or two either side
    KIND_NEAR_TOP     // just under 2^64
  } value_kind_e;

  // -------------------------------------------------------------------------
  // Scoreboard: one expected sum per accepted value, checked in order
  // -------------------------------------------------------------------------
  class digit_sum_board;
    sum_t expected_sums[$];
    int   noted;
    int   checked;
    int   mismatches;

    function new();
      noted      = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // Peel off one decimal digit at a time
    function sum_t digit_total(value_t v);
      value_t      rest;
      int unsigned total;
      rest  = v;
      total = 0;
      while (rest != 0) begin
        total += int'(rest % DECIMAL_BASE);
        rest  /= DECIMAL_BASE;
      end
      return sum_t'(total);
    endfunction

    function void note_value(value_t v);
      expected_sums.push_back(digit_total(v));
      noted++;
    endfunction

    function void check_sum(sum_t got);
      sum_t want;
      checked++;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("[%0t] unexpected sum word %0d with nothing outstanding", $time, got);
        end
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] sum word %0d: expected %0d, got %0d",
                     $time, checked, want, got);
          end
        end
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  dds_in_if  value_ch ();
  dds_out_if sum_ch ();

  decimal_digit_sum_top dut (
    .clk      (clk),
    .rst      (rst),
    .value_ch (value_ch),
    .sum_ch   (sum_ch)
  );

  digit_sum_board board;
  bit             calm;          // both sides stop idling while set
  int             input_stalls;  // cycles with a word offered but refused
  int             hold_left;
  bit             hold_done;

  // Clock: two delays, high then low
  initial clk = 1'b0;
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Random values, spread over shapes that stress carries in the conversion
  // -------------------------------------------------------------------------
  function automatic value_t random_value();
    value_kind_e kind;
    value_t      v;
    value_t      power;
    int          digits;
    int          d;
    kind = value_kind_e'($urandom_range(KIND_FULL, KIND_NEAR_TOP));
    v    = '0;
    case (kind)
      KIND_FULL: begin
        v = {$urandom, $urandom};
      end
      KIND_SMALL: begin
        v = value_t'($urandom_range(0, 999));
      end
      KIND_SHIFTED: begin
        v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
      end
      KIND_NINES: begin
        // at most 19 digits, so never past 2^64
        digits = $urandom_range(1, 19);
        for (int i = 0; i < digits; i++) begin
          d = ($urandom_range(0, 1) == 1) ? 9 : $urandom_range(0, 9);
          v = v * DECIMAL_BASE + value_t'(d);
        end
      end
      KIND_NEAR_POWER: begin
        power  = 64'd1;
        digits = $urandom_range(0, 19);
        for (int i = 0; i < digits; i++) begin
          power = power * DECIMAL_BASE;
        end
        // wraps below zero on purpose
        v = power + value_t'($urandom_range(0, 4)) - 64'd2;
      end
      default: begin
        v = 64'hFFFF_FFFF_FFFF_FFFF - value_t'($urandom_range(0, 1000));
      end
    endcase
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the word until it is taken
  // -------------------------------------------------------------------------
  task automatic send_value(input value_t v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    forever begin
      @(posedge clk);
      if (value_ch.ready) break;
      input_stalls++;
    end
    board.note_value(v);
  endtask

  // Edge cases: zero, digit roll-overs, powers of two and ten, the top of
  // the range and the largest possible sum
  value_t directed_values[] = '{
    64'd0,
    64'd1,
    64'd9,
    64'd10,
    64'd19,
    64'd99,
    64'd100,
    64'd999999999,
    64'd4294967295,
    64'd4294967296,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd1000000000000000000,
    64'd1999999999999999999,
    64'd9999999999999999999,   // nineteen nines: the largest sum
    64'd10000000000000000000,
    64'd12345678901234567890,
    64'd17999999999999999999,
    64'd18446744073709551609,
    64'hFFFF_FFFF_FFFF_FFFE,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  // -------------------------------------------------------------------------
  // Stimulus, drain and final verdict
  // -------------------------------------------------------------------------
  initial begin
    board          = new();
    calm           = 1'b0;
    input_stalls   = 0;
    rst            = 1'b1;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    for (int n = 0; n < RANDOM_VALUES; n++) begin
      calm = (n >= CALM_FIRST) && (n <= CALM_LAST);
      send_value(random_value());
    end
    calm = 1'b0;
    value_ch.valid <= 1'b0;

    // Wait for every sum, then a little past the pipeline depth in case
    // anything stray is still on its way
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d values (%0d edge cases), checked %0d sums, %0d mismatches.",
             board.noted, directed_values.size(), board.checked, board.mismatches);
    $display("Input held off for %0d cycles by result back-pressure.", input_stalls);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: check each taken word, then pick ready for the next edge.
  // One long hold-off lets the pipeline fill and stall the input.
  // -------------------------------------------------------------------------
  initial begin
    sum_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        sum_ch.ready <= 1'b0;
      end else begin
        if (sum_ch.valid && sum_ch.ready) begin
          board.check_sum(sum_ch.digit_sum);
        end
        if (!hold_done && board.checked >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          sum_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
          sum_ch.ready <= 1'b0;
        end else begin
          sum_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
